// ===== rtl/lfsa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest free slot allocator package
// Shared constants and the controller-to-datapath command type.
// ----------------------------------------------------------------------------
package lfsa_pkg;

   localparam int DEF_NUM_SLOTS  = 64;
   localparam int DEF_TIME_WIDTH = 32;

   localparam int TIME_FIELD_W = 32;
   localparam int SLOT_FIELD_W = 6;
   localparam int REQ_DATA_W   = 2 * TIME_FIELD_W;
   localparam int RSP_DATA_W   = 8;

   localparam int GRP_SIZE = 8;
   localparam int GRP_W    = $clog2(GRP_SIZE);

   typedef struct packed {
      logic load_req;
      logic cmp_en;
      logic grp_en;
      logic commit;
   } lfsa_cmd_type;

endpackage

// ===== rtl/lfsa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest free slot allocator controller
// Sequences one request through compare, group reduction and commit, and
// holds the result valid flag.
// ----------------------------------------------------------------------------
module lfsa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output lfsa_pkg::lfsa_cmd_type cmd
);
   import lfsa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CMP,
      ST_GRP,
      ST_PICK
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.cmp_en = 1'b1;
            state_in   = ST_GRP;
         end
         ST_GRP: begin
            cmd.grp_en = 1'b1;
            state_in   = ST_PICK;
         end
         ST_PICK: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/lfsa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest free slot allocator datapath
// Per-slot release times with parallel compares, a registered group
// reduction, the lowest-slot pick, write-back and the result register.
// ----------------------------------------------------------------------------
module lfsa_dp #(
   parameter int NUM_SLOTS  = lfsa_pkg::DEF_NUM_SLOTS,
   parameter int TIME_WIDTH = lfsa_pkg::DEF_TIME_WIDTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lfsa_pkg::lfsa_cmd_type             cmd,
   input  logic [lfsa_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic [lfsa_pkg::SLOT_FIELD_W-1:0]  granted_slot,
   output logic                               all_busy
);
   import lfsa_pkg::*;

   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int NGRP   = (NUM_SLOTS + GRP_SIZE - 1) / GRP_SIZE;
   localparam int NPAD   = NGRP * GRP_SIZE;

   logic [TIME_WIDTH-1:0]   rel_ff [NUM_SLOTS];
   logic [TIME_WIDTH-1:0]   arr_ff, dep_ff;
   logic [NPAD-1:0]         free_ff, free_in;
   logic [NGRP-1:0]         grp_any_ff, grp_any_in;
   logic [GRP_W-1:0]        grp_loc_ff [NGRP];
   logic [GRP_W-1:0]        grp_loc_in [NGRP];
   logic                    pick_hit;
   logic [SLOT_W-1:0]       pick_idx;
   logic [SLOT_FIELD_W-1:0] slot_ff;
   logic                    busy_ff;

   always_comb begin
      free_in = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         free_in[i] = (rel_ff[i] <= arr_ff);
      end
   end

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_any_in[g] = |free_ff[g*GRP_SIZE +: GRP_SIZE];
         grp_loc_in[g] = '0;
         for (int b = GRP_SIZE - 1; b >= 0; b--) begin
            if (free_ff[g*GRP_SIZE + b]) begin
               grp_loc_in[g] = GRP_W'(b);
            end
         end
      end
   end

   always_comb begin
      pick_hit = 1'b0;
      pick_idx = '0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            pick_hit = 1'b1;
            pick_idx = SLOT_W'(g * GRP_SIZE + int'(grp_loc_ff[g]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_SLOTS; i++) begin
            rel_ff[i] <= '0;
         end
      end else if (cmd.commit && pick_hit) begin
         rel_ff[pick_idx] <= dep_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         arr_ff <= TIME_WIDTH'(req_tdata[TIME_FIELD_W-1:0]);
         dep_ff <= TIME_WIDTH'(req_tdata[REQ_DATA_W-1:TIME_FIELD_W]);
      end
      if (cmd.cmp_en) begin
         free_ff <= free_in;
      end
      if (cmd.grp_en) begin
         grp_any_ff <= grp_any_in;
         grp_loc_ff <= grp_loc_in;
      end
      if (cmd.commit) begin
         slot_ff <= pick_hit ? SLOT_FIELD_W'(pick_idx) : '0;
         busy_ff <= !pick_hit;
      end
   end

   assign granted_slot = slot_ff;
   assign all_busy     = busy_ff;

endmodule

// ===== rtl/lowest_free_slot_timed_allocator_unit.sv =====
`timescale 1ns / 1ps
// A request passes through the compare, group reduction and commit steps in
// turn, and a new request is taken only once the last one commits; a stalled
// result holds the request in its final step until the result transaction
// completes.
// Reset clears every release time, so all slots start free.
// ----------------------------------------------------------------------------
// Lowest free slot timed allocator
// Grants the lowest-numbered slot whose release time is at most the arrival
// time and stores the departure time as its new release time.
// ----------------------------------------------------------------------------
module lowest_free_slot_timed_allocator_unit #(
   parameter int NUM_SLOTS  = lfsa_pkg::DEF_NUM_SLOTS,
   parameter int TIME_WIDTH = lfsa_pkg::DEF_TIME_WIDTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // Fields from bit 0: arrival_time[31:0], departure_time[63:32].
   input  logic [lfsa_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // Fields from bit 0: granted_slot[5:0], zero fill[7:6].
   output logic [lfsa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // Fields from bit 0: all_busy[0].
   output logic                             rsp_tuser
);
   import lfsa_pkg::*;

   lfsa_cmd_type            cmd;
   logic [SLOT_FIELD_W-1:0] granted_slot;

   lfsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   lfsa_dp #(
      .NUM_SLOTS  (NUM_SLOTS),
      .TIME_WIDTH (TIME_WIDTH)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_tdata    (req_tdata),
      .granted_slot (granted_slot),
      .all_busy     (rsp_tuser)
   );

   assign rsp_tdata = RSP_DATA_W'(granted_slot);

endmodule

// ===== rtl/lfsa_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest free slot allocator checker
// Port-level checks on the allocator, attached to the top level by bind.
// ----------------------------------------------------------------------------
module lfsa_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [lfsa_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tuser
);
   import lfsa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("Result changed while stalled.");

   a_busy_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("Refused request carries a non-zero slot.");

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Second request taken while one is in progress.");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("Result valid straight after reset.");

endmodule

bind lowest_free_slot_timed_allocator_unit lfsa_chk u_lfsa_chk (.*);
